>>> hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Types, operation codes and saturation helper for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIV_STEPS  = 33;   // quotient bits kept by the divider
  localparam int MLO_W      = DIV_STEPS - FRAC_BITS;
  localparam int QDEPTH     = 4;
  localparam int QAW        = 2;

  localparam logic [2:0] KIND_ADD  = 3'd0;
  localparam logic [2:0] KIND_SUB  = 3'd1;
  localparam logic [2:0] KIND_MUL  = 3'd2;
  localparam logic [2:0] KIND_DIV  = 3'd3;
  localparam logic [2:0] KIND_CONJ = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic [1:0]         status;
  } res_t;

  typedef struct packed {
    logic add;
    logic sub;
    logic mul;
    logic div;
    logic conj;
  } cls_t;

  typedef struct packed {
    cls_t               cls;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
  } itm_t;

  // sign/magnitude to saturated two's complement; returns {sat, value}
  function automatic logic [32:0] sat_pack(input logic neg, input logic [63:0] mag);
    logic [63:0] lim;
    logic [63:0] m;
    logic        sat;
    lim = 64'd1 << (DATA_WIDTH - 1);
    m   = mag;
    sat = 1'b0;
    if (neg) begin
      if (mag > lim) begin
        m   = lim;
        sat = 1'b1;
      end
      m = 64'd0 - m;
    end else if (mag > lim - 64'd1) begin
      m   = lim - 64'd1;
      sat = 1'b1;
    end
    return {sat, m[31:0]};
  endfunction

endpackage

>>> hdl/cau_fifo.sv
// ----------------------------------------------------------------------------
// cau_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module cau_fifo import cau_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  itm_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output itm_t pop_data
);

  itm_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

>>> hdl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Accepts input transactions and decodes the operation into a class vector.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
  input  logic in_push,
  output logic in_full,
  input  in_t  in_data,
  output logic q_push,
  output itm_t q_data,
  input  logic q_full
);

  cls_t cls;

  always_comb begin
    cls = '0;
    case (in_data.kind)
      KIND_ADD:  cls.add  = 1'b1;
      KIND_SUB:  cls.sub  = 1'b1;
      KIND_MUL:  cls.mul  = 1'b1;
      KIND_DIV:  cls.div  = 1'b1;
      KIND_CONJ: cls.conj = 1'b1;
      default:   cls = '0;   // unknown code gives a zero result
    endcase
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;
  assign q_data  = '{cls: cls, ar: in_data.a_real, ai: in_data.a_imag,
                     br: in_data.b_real, bi: in_data.b_imag};

endmodule

>>> hdl/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// Execution pipeline: products, sums, magnitudes, restoring divider, packing.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  itm_t q_data,
  output logic q_pop,
  output logic out_empty,
  input  logic out_pop,
  output res_t out_data
);

  typedef struct packed {
    logic              div;
    logic              dz;
    logic              ovf_re;
    logic              ovf_im;
    logic              neg_re;
    logic              neg_im;
    logic [63:0]       d;
    logic [MLO_W-1:0]  mlo_re;
    logic [MLO_W-1:0]  mlo_im;
    logic [31:0]       nd_re;
    logic [31:0]       nd_im;
    logic              nd_sat;
  } side_t;

  logic adv;

  // whole pipeline moves together when the output register can take a result
  assign adv   = !out_empty || out_pop ? (out_empty || out_pop) : 1'b1;
  assign q_pop = adv && !q_empty;

  // stage 0: operands
  logic s0_v_r;
  itm_t s0_r;
  // stage 1: products
  logic               s1_v_r;
  cls_t               s1_cls_r;
  logic signed [31:0] s1_ar_r, s1_ai_r, s1_br_r, s1_bi_r;
  logic signed [63:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic [63:0]        sq_r_r, sq_i_r;
  // stage 2: signed sums and divisor
  logic               s2_v_r;
  cls_t               s2_cls_r;
  logic signed [64:0] v_re_r, v_im_r, v_re_nxt, v_im_nxt;
  logic [63:0]        d_r;

  // divider stages, index 0 is the divider input
  logic        dv_r  [DIV_STEPS+1];
  side_t       sd_r  [DIV_STEPS+1];
  logic [63:0] rre_r [DIV_STEPS+1];
  logic [63:0] rim_r [DIV_STEPS+1];
  logic [32:0] qre_r [DIV_STEPS+1];
  logic [32:0] qim_r [DIV_STEPS+1];

  logic out_v_r;
  res_t out_r, out_nxt;

  assign out_empty = !out_v_r;
  assign out_data  = out_r;

  always_comb begin
    v_re_nxt = '0;
    v_im_nxt = '0;
    if (s1_cls_r.add) begin
      v_re_nxt = 65'(s1_ar_r) + 65'(s1_br_r);
      v_im_nxt = 65'(s1_ai_r) + 65'(s1_bi_r);
    end else if (s1_cls_r.sub) begin
      v_re_nxt = 65'(s1_ar_r) - 65'(s1_br_r);
      v_im_nxt = 65'(s1_ai_r) - 65'(s1_bi_r);
    end else if (s1_cls_r.mul) begin
      v_re_nxt = 65'(p_rr_r) - 65'(p_ii_r);
      v_im_nxt = 65'(p_ri_r) + 65'(p_ir_r);
    end else if (s1_cls_r.div) begin
      v_re_nxt = 65'(p_rr_r) + 65'(p_ii_r);
      v_im_nxt = 65'(p_ir_r) - 65'(p_ri_r);
    end else if (s1_cls_r.conj) begin
      v_re_nxt = 65'(s1_ar_r);
      v_im_nxt = -65'(s1_ai_r);
    end
  end

  // stage 3: magnitudes, overflow precheck, non-divide packing
  logic [63:0] mag_re, mag_im, nd_mre, nd_mim;
  logic [32:0] pk_re, pk_im;
  side_t       sd0_nxt;

  always_comb begin
    mag_re  = v_re_r[64] ? 64'(-v_re_r) : v_re_r[63:0];
    mag_im  = v_im_r[64] ? 64'(-v_im_r) : v_im_r[63:0];
    nd_mre  = s2_cls_r.mul ? (mag_re >> FRAC_BITS) : mag_re;
    nd_mim  = s2_cls_r.mul ? (mag_im >> FRAC_BITS) : mag_im;
    pk_re   = sat_pack(v_re_r[64], nd_mre);
    pk_im   = sat_pack(v_im_r[64], nd_mim);
    sd0_nxt.div    = s2_cls_r.div;
    sd0_nxt.dz     = (d_r == '0);
    // quotient would need more than DIV_STEPS bits
    sd0_nxt.ovf_re = {{MLO_W{1'b0}}, mag_re} >= {d_r, {MLO_W{1'b0}}};
    sd0_nxt.ovf_im = {{MLO_W{1'b0}}, mag_im} >= {d_r, {MLO_W{1'b0}}};
    sd0_nxt.neg_re = v_re_r[64];
    sd0_nxt.neg_im = v_im_r[64];
    sd0_nxt.d      = d_r;
    sd0_nxt.mlo_re = mag_re[MLO_W-1:0];
    sd0_nxt.mlo_im = mag_im[MLO_W-1:0];
    sd0_nxt.nd_re  = pk_re[31:0];
    sd0_nxt.nd_im  = pk_im[31:0];
    sd0_nxt.nd_sat = pk_re[32] || pk_im[32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r   <= 1'b0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      dv_r[0]  <= 1'b0;
    end else if (adv) begin
      s0_v_r   <= !q_empty;
      s1_v_r   <= s0_v_r;
      s2_v_r   <= s1_v_r;
      dv_r[0]  <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r     <= q_data;
      s1_cls_r <= s0_r.cls;
      s1_ar_r  <= s0_r.ar;
      s1_ai_r  <= s0_r.ai;
      s1_br_r  <= s0_r.br;
      s1_bi_r  <= s0_r.bi;
      p_rr_r   <= 64'(s0_r.ar) * 64'(s0_r.br);
      p_ii_r   <= 64'(s0_r.ai) * 64'(s0_r.bi);
      p_ri_r   <= 64'(s0_r.ar) * 64'(s0_r.bi);
      p_ir_r   <= 64'(s0_r.ai) * 64'(s0_r.br);
      sq_r_r   <= 64'(64'(s0_r.br) * 64'(s0_r.br));
      sq_i_r   <= 64'(64'(s0_r.bi) * 64'(s0_r.bi));
      s2_cls_r <= s1_cls_r;
      v_re_r   <= v_re_nxt;
      v_im_r   <= v_im_nxt;
      d_r      <= sq_r_r + sq_i_r;
      sd_r[0]  <= sd0_nxt;
      rre_r[0] <= mag_re >> MLO_W;
      rim_r[0] <= mag_im >> MLO_W;
      qre_r[0] <= '0;
      qim_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int BI = DIV_STEPS - 1 - k;
    logic        nb_re, nb_im;
    logic [63:0] tr, ti;

    if (BI >= FRAC_BITS) begin : g_bit
      assign nb_re = sd_r[k].mlo_re[BI-FRAC_BITS];
      assign nb_im = sd_r[k].mlo_im[BI-FRAC_BITS];
    end else begin : g_zero
      assign nb_re = 1'b0;
      assign nb_im = 1'b0;
    end

    assign tr = {rre_r[k][62:0], nb_re};
    assign ti = {rim_r[k][62:0], nb_im};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd_r[k+1] <= sd_r[k];
        if (tr >= sd_r[k].d) begin
          rre_r[k+1] <= tr - sd_r[k].d;
          qre_r[k+1] <= {qre_r[k][31:0], 1'b1};
        end else begin
          rre_r[k+1] <= tr;
          qre_r[k+1] <= {qre_r[k][31:0], 1'b0};
        end
        if (ti >= sd_r[k].d) begin
          rim_r[k+1] <= ti - sd_r[k].d;
          qim_r[k+1] <= {qim_r[k][31:0], 1'b1};
        end else begin
          rim_r[k+1] <= ti;
          qim_r[k+1] <= {qim_r[k][31:0], 1'b0};
        end
      end
    end
  end

  // final packing
  side_t       sf;
  logic [32:0] dq_re, dq_im;

  always_comb begin
    sf    = sd_r[DIV_STEPS];
    dq_re = sat_pack(sf.neg_re, sf.ovf_re ? '1 : {31'd0, qre_r[DIV_STEPS]});
    dq_im = sat_pack(sf.neg_im, sf.ovf_im ? '1 : {31'd0, qim_r[DIV_STEPS]});
    if (sf.div && sf.dz) begin
      out_nxt = '{res_real: '0, res_imag: '0, status: ST_DIVZ};
    end else if (sf.div) begin
      out_nxt.res_real = dq_re[31:0];
      out_nxt.res_imag = dq_im[31:0];
      out_nxt.status   = (dq_re[32] || dq_im[32]) ? ST_SAT : ST_OK;
    end else begin
      out_nxt.res_real = sf.nd_re;
      out_nxt.res_imag = sf.nd_im;
      out_nxt.status   = sf.nd_sat ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> hdl/complex_arithmetic_unit.sv
// Path from accept to result: operand register, product, sum and magnitude
//   stages, 33 divider stages, output register, for every operation.
// Throughput: one transaction per cycle unless output stalls; the restoring
//   divider takes one quotient bit per stage, so it never blocks the next item.
// Reset: synchronous, active low; clears the queue and all valid bits.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply, divide and conjugate on Q16.16 operands.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  in_t  in_data,
  output logic out_empty,
  input  logic out_pop,
  output res_t out_data
);

  logic q_push, q_full, q_pop, q_empty;
  itm_t q_wdata, q_rdata;

  cau_front u_front (
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  cau_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_rdata)
  );

  cau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the complex arithmetic unit. Directed corner cases
// come first, then random operands of mixed magnitude. A class-based
// scoreboard predicts each result and compares it in order. Idling on both
// sides is randomized, in three phases.
// ----------------------------------------------------------------------------
module tb_top import cau_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] KIND_RSVD  = 3'd5;
  localparam logic [2:0] KIND_UNDEF = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 45;

  class cau_scoreboard;
    res_t pending[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    // two's complement sum to sign and magnitude
    function automatic logic [63:0] to_mag(input logic [63:0] u, output logic neg);
      neg = (u > 64'h8000_0000_0000_0000);
      return neg ? (64'd0 - u) : u;
    endfunction

    function automatic logic [31:0] clamp(input logic neg, input logic [63:0] mag,
                                          inout logic sat);
      logic [63:0] m;
      m = mag;
      if (neg) begin
        if (m > 64'h8000_0000) begin
          m = 64'h8000_0000;
          sat = 1'b1;
        end
        m = 64'd0 - m;
      end else if (m > 64'h7FFF_FFFF) begin
        m = 64'h7FFF_FFFF;
        sat = 1'b1;
      end
      return m[31:0];
    endfunction

    // (mag << FRAC_BITS) / d, all ones when clearly out of range
    function automatic logic [63:0] quot_fix(input logic [63:0] mag, input logic [63:0] d);
      logic [63:0] qi, rem, frac;
      qi = mag / d;
      rem = mag % d;
      frac = 0;
      if (qi > (64'h8000_0000 >> FRAC_BITS)) return '1;
      for (int i = 0; i < FRAC_BITS; i++) begin
        rem = rem << 1;
        frac = frac << 1;
        if (rem >= d) begin
          rem = rem - d;
          frac[0] = 1'b1;
        end
      end
      return (qi << FRAC_BITS) | frac;
    endfunction

    function automatic res_t compute(input in_t x);
      logic signed [63:0] ar, ai, br, bi;
      logic [63:0] mr, mi, d;
      logic nr, ni, sat;
      res_t r;
      ar = x.a_real;
      ai = x.a_imag;
      br = x.b_real;
      bi = x.b_imag;
      sat = 1'b0;
      r = '0;
      case (x.kind)
        KIND_ADD: begin
          mr = to_mag(ar + br, nr);
          mi = to_mag(ai + bi, ni);
        end
        KIND_SUB: begin
          mr = to_mag(ar - br, nr);
          mi = to_mag(ai - bi, ni);
        end
        KIND_MUL: begin
          mr = to_mag(ar * br - ai * bi, nr) >> FRAC_BITS;
          mi = to_mag(ar * bi + ai * br, ni) >> FRAC_BITS;
        end
        KIND_DIV: begin
          d = br * br + bi * bi;
          if (d == 0) begin
            r.status = ST_DIVZ;
            return r;
          end
          mr = quot_fix(to_mag(ar * br + ai * bi, nr), d);
          mi = quot_fix(to_mag(ai * br - ar * bi, ni), d);
        end
        KIND_CONJ: begin
          mr = to_mag(ar, nr);
          mi = to_mag(-ai, ni);
        end
        default: return r;
      endcase
      r.res_real = clamp(nr, mr, sat);
      r.res_imag = clamp(ni, mi, sat);
      r.status = sat ? ST_SAT : ST_OK;
      return r;
    endfunction

    function void note_input(input in_t x);
      pending.push_back(compute(x));
    endfunction

    function void check_result(input res_t got);
      res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.res_real !== want.res_real) begin
        $display("%0t: res_real exp %h act %h", $realtime, want.res_real, got.res_real);
        errors++;
      end
      if (got.res_imag !== want.res_imag) begin
        $display("%0t: res_imag exp %h act %h", $realtime, want.res_imag, got.res_imag);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status exp %0d act %0d", $realtime, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_push, in_full, out_empty, out_pop;
  in_t  in_data;
  res_t out_data;
  int   tx_idle, rx_idle, cycles;
  cau_scoreboard sb;

  complex_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_data(in_data), .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side: check on accept, then pick next pop
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) sb.check_result(out_data);
      out_pop <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic push_item(input in_t x);
    while ($urandom_range(99) < tx_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_input(x);
  endtask

  task automatic push_op(input logic [2:0] k, input logic [31:0] ar, input logic [31:0] ai,
                         input logic [31:0] br, input logic [31:0] bi);
    in_t x;
    x.kind = k;
    x.a_real = ar;
    x.a_imag = ai;
    x.b_real = br;
    x.b_imag = bi;
    push_item(x);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(6))
      0: return $urandom;
      1: return 32'sd0;
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
      default: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
    endcase
  endfunction

  task automatic run_random(input int n);
    logic [2:0] k;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      push_op(k, rand_operand(), rand_operand(), rand_operand(), rand_operand());
    end
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_push = 1'b0;
    out_pop = 1'b0;
    in_data = '0;
    tx_idle = 9;
    rx_idle = 86;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner cases
    push_op(KIND_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    push_op(KIND_ADD, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000);
    push_op(KIND_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    push_op(KIND_SUB, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 32'h0002_0000);
    push_op(KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_op(KIND_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    push_op(KIND_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000);
    push_op(KIND_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
    push_op(KIND_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
    push_op(KIND_DIV, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    push_op(KIND_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
    push_op(KIND_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
    push_op(KIND_DIV, 32'h0005_0000, 32'hFFFD_0000, 32'h0001_0000, 32'h0002_0000);
    push_op(KIND_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    push_op(KIND_DIV, 32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_op(KIND_CONJ, 32'h1234_5678, 32'h8000_0000, 32'h0, 32'h0);
    push_op(KIND_CONJ, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(KIND_CONJ, 32'h0, 32'h0, 32'h0, 32'h0);
    push_op(KIND_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(KIND_UNDEF, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);

    // hold off the sender until everything is out
    in_push <= 1'b0;
    @(posedge clk);
    wait_drained();

    run_random(220);
    tx_idle = 86;
    rx_idle = 9;
    run_random(220);
    tx_idle = 0;
    rx_idle = 0;
    run_random(210);
    in_push <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
